### sv/ssg_pkg.sv
// shared types, constants and the elaboration-time quarter-wave sine table
// builder for the sine sample generator; no dependencies
package ssg_pkg;

	localparam int unsigned INDEX_BITS    = 12;
	localparam int unsigned ROM_ADDR_BITS = 10;
	localparam int unsigned QUARTER       = 1 << ROM_ADDR_BITS;
	localparam int unsigned MAG_BITS      = 23;
	localparam int unsigned AMP_BITS      = 18;
	localparam int unsigned PROD_BITS     = MAG_BITS + AMP_BITS;
	localparam int unsigned CFG_IDX_BITS  = 2;

	localparam logic [MAG_BITS-1:0] FULL_SCALE = 23'd8388607;
	localparam logic [63:0]         HALF_PI_Q60 = 64'h1921FB54442D1846;

	localparam logic [31:0]         PHASE_STEP_RESET = 32'd22817013;
	localparam logic [AMP_BITS-1:0] AMPLITUDE_RESET  = 18'd65536;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PHASE_STEP = 2'd0,
		REG_AMPLITUDE  = 2'd1
	} ssg_reg_t;

	typedef logic [MAG_BITS-1:0]    ssg_mag_t;
	typedef logic [ROM_ADDR_BITS:0] ssg_addr_t;
	typedef ssg_mag_t ssg_table_t [QUARTER+1];

	// (a * b) >> 60, kept to 64 bits
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// divide a taylor term by (2n)(2n+1)
	function automatic logic [63:0] taylor_div(input logic [63:0] v, input int n);
		logic [63:0] r;
		case (n)
			1:       r = v / 6;
			2:       r = v / 20;
			3:       r = v / 42;
			4:       r = v / 72;
			5:       r = v / 110;
			6:       r = v / 156;
			7:       r = v / 210;
			8:       r = v / 272;
			9:       r = v / 342;
			10:      r = v / 420;
			11:      r = v / 506;
			12:      r = v / 600;
			13:      r = v / 702;
			14:      r = v / 812;
			15:      r = v / 930;
			16:      r = v / 1056;
			17:      r = v / 1190;
			18:      r = v / 1332;
			19:      r = v / 1482;
			default: r = v;
		endcase
		return r;
	endfunction

	// round(8388607 * sin(k*pi/(2*QUARTER))) for k = 0..QUARTER, Q60 taylor series
	function automatic ssg_table_t build_quarter_wave();
		ssg_table_t   tbl;
		logic [63:0]  step;
		logic [63:0]  x;
		logic [63:0]  x2;
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [63:0]  r;
		logic [127:0] p;
		int           k;
		int           n;
		step = HALF_PI_Q60 >> ROM_ADDR_BITS;
		for (k = 0; k <= QUARTER; k++) begin
			if (k == QUARTER) begin
				x = HALF_PI_Q60;
			end else begin
				x = step * 64'(k);
			end
			x2   = mul_q60(x, x);
			term = x;
			sum  = x;
			for (n = 1; n < 20; n++) begin
				if (term != 64'd0) begin
					term = taylor_div(mul_q60(term, x2), n);
					if (n[0]) begin
						sum = sum - term;
					end else begin
						sum = sum + term;
					end
				end
			end
			p = {64'd0, sum} * {64'd0, 41'd0, FULL_SCALE} + (128'd1 << 59);
			r = p[123:60];
			tbl[k] = (r > {41'd0, FULL_SCALE}) ? FULL_SCALE : r[MAG_BITS-1:0];
		end
		return tbl;
	endfunction

endpackage

### sv/ssg_sine_rom.sv
// quarter-wave sine rom with registered read, table built at elaboration
// depends on ssg_pkg
module ssg_sine_rom (
	input  logic             clk,
	input  logic             en,
	input  ssg_pkg::ssg_addr_t addr,
	output ssg_pkg::ssg_mag_t  mag
);
	import ssg_pkg::*;

	localparam ssg_table_t QUARTER_WAVE = build_quarter_wave();

	ssg_mag_t mag_q;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= QUARTER_WAVE[addr];
		end
	end

	assign mag = mag_q;

endmodule

### sv/sine_sample_generator_24bit.sv
// sine sample generator: index -> phase -> quarter-wave lookup -> gain -> i2s word
// depends on ssg_pkg and ssg_sine_rom
//
// usage
//   in channel  : in_valid/in_ready with sample_index; one beat per sample
//   out channel : out_valid/out_ready with sample_word (24-bit sample in the top
//                 bits, low byte zero) and clipped (gain pushed it past full scale)
//   cfg channel : cfg_valid/cfg_ready, cfg_index 0 = phase_step, 1 = amplitude
//                 (q16); other indexes are dropped. cfg_ready is always high;
//                 write only while no sample is in flight
//   latency     : five cycles from an input beat to its output beat
//   throughput  : one sample per cycle; five register stages (phase multiply,
//                 quadrant fold, rom read, gain multiply, saturate and sign)
//   reset       : pipeline empties, registers return to 22817013 and 65536
//   stall       : when out_ready is low with a beat waiting, the whole pipeline
//                 holds and in_ready drops; nothing is lost or repeated
module sine_sample_generator_24bit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [11:0]                          sample_index,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [31:0]                          sample_word,
	output logic                                 clipped,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ssg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [31:0]                          cfg_data
);
	import ssg_pkg::*;

	localparam ssg_addr_t QUARTER_A = ssg_addr_t'(QUARTER);

	logic [31:0]         phase_step_q;
	logic [AMP_BITS-1:0] amplitude_q;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [INDEX_BITS+31:0] phase_full;
	logic [31:0]            phase_s1;
	logic [1:0]             quad;
	ssg_addr_t              addr_raw;
	ssg_addr_t              addr_s2;
	logic                   neg_s2;
	ssg_mag_t               mag_s3;
	logic                   neg_s3;
	logic [PROD_BITS-1:0]   prod_s4;
	logic                   neg_s4;
	logic [PROD_BITS-17:0]  scaled;
	logic                   clip;
	ssg_mag_t               mag_sat;
	logic [MAG_BITS:0]      signed_sample;
	logic [31:0]            word_s5;
	logic                   clip_s5;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_STEP_RESET;
			amplitude_q  <= AMPLITUDE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PHASE_STEP: phase_step_q <= cfg_data;
				REG_AMPLITUDE:  amplitude_q  <= cfg_data[AMP_BITS-1:0];
				default:        ;
			endcase
		end
	end

	// whole pipeline moves together unless the output beat is stuck
	assign adv      = !v_s5 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: phase = index * step mod 2^32
	assign phase_full = {32'd0, sample_index[INDEX_BITS-1:0]}
		* {{INDEX_BITS{1'b0}}, phase_step_q};

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s1 <= phase_full[31:0];
		end
	end

	// stage 2: quadrant fold onto the quarter table
	assign quad     = phase_s1[31:30];
	assign addr_raw = {1'b0, phase_s1[29 -: ROM_ADDR_BITS]};

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s2 <= quad[0] ? (QUARTER_A - addr_raw) : addr_raw;
			neg_s2  <= quad[1];
		end
	end

	// stage 3: table read
	ssg_sine_rom u_rom (
		.clk  (clk),
		.en   (adv),
		.addr (addr_s2),
		.mag  (mag_s3)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s3 <= neg_s2;
		end
	end

	// stage 4: gain
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4 <= {{AMP_BITS{1'b0}}, mag_s3} * {{MAG_BITS{1'b0}}, amplitude_q};
			neg_s4  <= neg_s3;
		end
	end

	// stage 5: drop q16 fraction, saturate, apply sign, msb-align
	assign scaled  = prod_s4[PROD_BITS-1:16];
	assign clip    = scaled > {{(PROD_BITS-16-MAG_BITS){1'b0}}, FULL_SCALE};
	assign mag_sat = clip ? FULL_SCALE : scaled[MAG_BITS-1:0];
	assign signed_sample = neg_s4 ? ((MAG_BITS+1)'(0) - {1'b0, mag_sat}) : {1'b0, mag_sat};

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s5 <= {signed_sample, 8'h00};
			clip_s5 <= clip;
		end
	end

	assign out_valid   = v_s5;
	assign sample_word = word_s5;
	assign clipped     = clip_s5;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// testbench for sine_sample_generator_24bit: drives index beats and register writes,
// predicts each sample with its own quarter-wave table and checks every output beat
// depends on ssg_pkg and the sine_sample_generator_24bit rtl
module testbench;

	localparam int PIPE_DEPTH      = 5;
	localparam int QUIET_LIMIT     = 4000;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 54;
	localparam int TABLE_LAST      = 1 << ssg_pkg::ROM_ADDR_BITS;
	localparam int ADDR_TOP        = 29;
	localparam logic [63:0] QUARTER_TURN_Q60 = 64'h1921FB54442D1846;
	localparam logic [22:0] PEAK             = 23'd8388607;

	// register indexes with no register behind them
	localparam logic [ssg_pkg::CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [ssg_pkg::CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [31:0] word;
		logic        clip;
	} sine_result_t;

	class sine_checker;
		logic [22:0]  quarter_wave [0:TABLE_LAST];
		logic [31:0]  step;
		logic [17:0]  gain;
		sine_result_t expected_samples [$];
		int           error_count;
		int           checked_count;
		int           clip_count;

		function new();
			logic [63:0]  angle_step;
			logic [63:0]  x;
			logic [63:0]  x2;
			logic [63:0]  term;
			logic [63:0]  acc;
			logic [127:0] wide;
			logic [63:0]  rounded;
			step          = ssg_pkg::PHASE_STEP_RESET;
			gain          = ssg_pkg::AMPLITUDE_RESET;
			error_count   = 0;
			checked_count = 0;
			clip_count    = 0;
			angle_step    = QUARTER_TURN_Q60 >> ssg_pkg::ROM_ADDR_BITS;
			for (int k = 0; k <= TABLE_LAST; k++) begin
				x    = (k == TABLE_LAST) ? QUARTER_TURN_Q60 : angle_step * 64'(k);
				x2   = q60_mul(x, x);
				term = x;
				acc  = x;
				// taylor series, alternating signs, stops once the term vanishes
				for (int n = 1; n < 20; n++) begin
					if (term != 64'd0) begin
						term = q60_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
						if (n % 2 == 1) begin
							acc = acc - term;
						end else begin
							acc = acc + term;
						end
					end
				end
				wide    = {64'd0, acc} * 128'(PEAK) + (128'd1 << 59);
				rounded = wide[123:60];
				quarter_wave[k] = (rounded > 64'(PEAK)) ? PEAK : rounded[22:0];
			end
		endfunction

		function logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
			logic [127:0] w;
			w = {64'd0, a} * {64'd0, b};
			return w[123:60];
		endfunction

		function void note_config(logic [ssg_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] data);
			case (idx)
				ssg_pkg::REG_PHASE_STEP: begin
					step = data;
				end
				ssg_pkg::REG_AMPLITUDE: begin
					gain = data[17:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void note_index(logic [11:0] idx);
			logic [31:0]  phase;
			logic [1:0]   quad;
			logic [10:0]  addr;
			logic [40:0]  scaled;
			logic [31:0]  level;
			sine_result_t r;
			phase = step * 32'(idx);
			quad  = phase[31:30];
			addr  = {1'b0, phase[ADDR_TOP -: ssg_pkg::ROM_ADDR_BITS]};
			// odd quadrants read the table backwards
			if (quad[0]) begin
				addr = 11'(TABLE_LAST) - addr;
			end
			scaled = (41'(quarter_wave[addr]) * 41'(gain)) >> 16;
			r.clip = scaled > 41'(PEAK);
			level  = r.clip ? 32'(PEAK) : scaled[31:0];
			if (quad[1]) begin
				level = -level;
			end
			r.word = {level[23:0], 8'h00};
			expected_samples.push_back(r);
		endfunction

		function void report_mismatch(string what);
			$display("mismatch at %0t: %s", $time, what);
			error_count++;
		endfunction

		function void check_sample(logic [31:0] word, logic clip);
			sine_result_t e;
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("output beat %h/%b with nothing pending", word, clip));
			end else begin
				e = expected_samples.pop_front();
				checked_count++;
				if (e.clip) begin
					clip_count++;
				end
				if (word !== e.word) begin
					report_mismatch($sformatf("sample_word %h, wanted %h", word, e.word));
				end
				if (clip !== e.clip) begin
					report_mismatch($sformatf("clipped %b, wanted %b", clip, e.clip));
				end
			end
		endfunction
	endclass

	logic                                clk          = 1'b0;
	logic                                arst_n       = 1'b0;
	logic                                in_valid     = 1'b0;
	logic                                in_ready;
	logic [11:0]                         sample_index = 12'd0;
	logic                                out_valid;
	logic                                out_ready    = 1'b0;
	logic [31:0]                         sample_word;
	logic                                clipped;
	logic                                cfg_valid    = 1'b0;
	logic                                cfg_ready;
	logic [ssg_pkg::CFG_IDX_BITS-1:0]    cfg_index    = '0;
	logic [31:0]                         cfg_data     = 32'd0;

	int          send_gap_pct  = 0;
	int          rx_stall_pct  = 0;
	int          quiet_cycles  = 0;
	sine_checker tracker;

	sine_sample_generator_24bit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_index (sample_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_word  (sample_word),
		.clipped      (clipped),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.check_sample(sample_word, clipped);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: %0d cycles without a beat", quiet_cycles);
			$display("sine_sample_generator_24bit verification failed");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the beat
	task automatic send_index(logic [11:0] idx);
		while ($urandom_range(99, 0) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		sample_index <= idx;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		tracker.note_index(idx);
		@(negedge clk);
	endtask

	task automatic drain();
		while (tracker.expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_DEPTH + 3) @(negedge clk);
	endtask

	task automatic write_reg(logic [ssg_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		tracker.note_config(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] step_value;
		logic [31:0] gain_value;
		int          settings;
		tracker  = new();
		settings = 1;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values of both registers
		send_index(12'd0);
		send_index(12'd4095);
		send_index(12'd1);
		send_index(12'd2048);
		send_index(12'hAAA);
		send_index(12'h555);
		in_valid <= 1'b0;

		// quarter-turn step lands on each quadrant boundary, double gain clips the peaks
		write_reg(ssg_pkg::REG_PHASE_STEP, 32'h4000_0000);
		write_reg(ssg_pkg::REG_AMPLITUDE, 32'd131072);
		settings++;
		send_index(12'd0);
		send_index(12'd1);
		send_index(12'd2);
		send_index(12'd3);
		in_valid <= 1'b0;

		// one table entry per index, zero gain
		write_reg(ssg_pkg::REG_PHASE_STEP, 32'h0010_0000);
		write_reg(ssg_pkg::REG_AMPLITUDE, 32'd0);
		settings++;
		send_index(12'd0);
		send_index(12'd1023);
		send_index(12'd4095);
		in_valid <= 1'b0;

		// largest step and largest 18-bit gain
		write_reg(ssg_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(ssg_pkg::REG_AMPLITUDE, 32'h0003_FFFF);
		settings++;
		send_index(12'd4095);
		send_index(12'd2);
		send_index(12'd1024);
		in_valid <= 1'b0;

		// zero step, then writes to unused indexes must change nothing
		write_reg(ssg_pkg::REG_PHASE_STEP, 32'd0);
		write_reg(ssg_pkg::REG_AMPLITUDE, 32'd65536);
		write_reg(REG_SPARE_A, 32'h1234_5678);
		write_reg(REG_SPARE_B, 32'h0000_0000);
		settings++;
		send_index(12'd4095);
		send_index(12'd7);
		in_valid <= 1'b0;

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 4)
				0: begin
					send_gap_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					send_gap_pct = 85;
					rx_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					rx_stall_pct = 85;
				end
				default: begin
					send_gap_pct = 11;
					rx_stall_pct = 11;
				end
			endcase
			case ($urandom_range(3, 0))
				0:       step_value = $urandom;
				1:       step_value = {12'($urandom_range(4095, 0)), 20'd0};
				2:       step_value = $urandom_range(65535, 0);
				default: step_value = ssg_pkg::PHASE_STEP_RESET + $urandom_range(4095, 0);
			endcase
			case ($urandom_range(5, 0))
				0:       gain_value = 32'd0;
				1:       gain_value = 32'd65536;
				2:       gain_value = 32'd131072;
				3:       gain_value = 32'h0003_FFFF;
				4:       gain_value = $urandom_range(131072, 0);
				default: gain_value = $urandom_range(32'h0003_FFFF, 0);
			endcase
			write_reg(ssg_pkg::REG_PHASE_STEP, step_value);
			write_reg(ssg_pkg::REG_AMPLITUDE, gain_value);
			settings++;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_index(12'($urandom_range(4095, 0)));
			end
			in_valid <= 1'b0;
		end

		drain();
		$display("checked %0d samples over %0d register settings, %0d of them saturated",
			tracker.checked_count, settings, tracker.clip_count);
		$display("idle patterns: none, sender gaps, receiver stalls, both");
		if (tracker.error_count == 0) begin
			$display("sine_sample_generator_24bit verification clean");
		end else begin
			$display("sine_sample_generator_24bit verification failed");
		end
		$finish;
	end

endmodule

### sim.f
sv/ssg_pkg.sv
sv/ssg_sine_rom.sv
sv/sine_sample_generator_24bit.sv
test/testbench.sv
